@@ hw/rtl/dhcp_pkg.sv @@
// Package for the DHCP reply parser: shared types, constants and codes.
// No dependencies.
package dhcp_pkg;

  localparam int unsigned MaxPacketBytes = 1024;
  localparam int unsigned PosW = 16;
  localparam logic [31:0] XidReset = 32'hDEADBEEF;
  localparam logic [15:0] PortReset = 16'd67;
  localparam logic [31:0] MaskReset = 32'hFFFFFF00;

  localparam logic [0:0] CfgXid  = 1'b0;
  localparam logic [0:0] CfgPort = 1'b1;

  localparam logic [7:0] OptPad    = 8'd0;
  localparam logic [7:0] OptMask   = 8'd1;
  localparam logic [7:0] OptRouter = 8'd3;
  localparam logic [7:0] OptType   = 8'd53;
  localparam logic [7:0] OptServer = 8'd54;
  localparam logic [7:0] OptEnd    = 8'd255;
  localparam logic [7:0] MsgOffer  = 8'd2;
  localparam logic [7:0] MsgAck    = 8'd5;

  typedef enum logic [1:0] {
    PhCode, PhLength, PhSkip, PhDone
  } phase_e;

  typedef enum logic [3:0] {
    VdPort, VdShort, VdLong, VdXid, VdCookie, VdNoType, VdIgnored, VdOffer, VdAck
  } verdict_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [15:0] udp_port;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] offered_address;
    logic [31:0] server_address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
    logic        lease_bound;
  } result_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'd99;
      2'd1: r = 8'd130;
      2'd2: r = 8'd83;
      default: r = 8'd99;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/dhcp_if.sv @@
// Valid/ready channel carrying one payload type.
// Has no dependencies; the payload type is a parameter.
interface dhcp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/dhcp_reply_parser.sv @@
// DHCP reply parser: checks a reply byte stream and keeps the lease state.
// The final byte passes through the input register and then the result register.
// Throughput: one byte per cycle; the input register stalls only when the
// result register is full and not taken.
// Reset: async active low; registers return to 0xDEADBEEF / 67, packet and
// session state clear (the subnet mask to 0xFFFFFF00). Depends on dhcp_pkg and dhcp_if.
module dhcp_reply_parser #(
  parameter int unsigned MAX_PACKET_BYTES = dhcp_pkg::MaxPacketBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dhcp_if.sink        in_if,
  dhcp_if.source      out_if,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import dhcp_pkg::*;

  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET_BYTES);

  logic [31:0] xid_q;
  logic [15:0] port_q;

  // input register
  logic  in_vld_q;
  item_t in_q;
  logic  out_vld_q;
  result_t out_q;
  logic  fire;

  assign fire = in_vld_q && (!in_q.last_byte || in_q.operation || !out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || fire;
  assign out_if.valid = out_vld_q;
  assign out_if.data = out_q;

  // packet state
  logic [PosW-1:0] pos_q, pos_d;
  logic xm_q, xm_d, cm_q, cm_d;
  logic [31:0] yi_q, yi_d, si_q, si_d;
  phase_e ph_q, ph_d;
  logic [7:0] skip_q, skip_d;
  logic ts_q, ts_d, tp_q, tp_d;
  logic [7:0] tv_q, tv_d;
  logic [31:0] ov_q [3], ov_d [3];
  logic [2:0] of_q, of_d;
  logic [2:0] ow_q [3], ow_d [3];
  // session state
  logic ot_q, ot_d, at_q, at_d;
  logic [31:0] la_q, la_d, ls_q, ls_d, lm_q, lm_d, lg_q, lg_d;
  verdict_e vd;

  always_comb begin
    logic [7:0] b;
    logic [7:0] tcode [3];
    logic [1:0] bi;
    b = in_q.data_byte;
    tcode[0] = OptServer; tcode[1] = OptMask; tcode[2] = OptRouter;
    bi = pos_q[1:0];
    pos_d = pos_q; xm_d = xm_q; cm_d = cm_q; yi_d = yi_q; si_d = si_q;
    ph_d = ph_q; skip_d = skip_q; ts_d = ts_q; tp_d = tp_q; tv_d = tv_q;
    ov_d = ov_q; of_d = of_q; ow_d = ow_q;
    ot_d = ot_q; at_d = at_q; la_d = la_q; ls_d = ls_q; lm_d = lm_q; lg_d = lg_q;
    vd = VdIgnored;
    if (pos_q >= PosW'(4) && pos_q <= PosW'(7)) begin
      if (b != xid_q[8*(3-bi) +: 8]) xm_d = 1'b0;
    end else if (pos_q >= PosW'(16) && pos_q <= PosW'(19)) begin
      yi_d = {yi_q[23:0], b};
    end else if (pos_q >= PosW'(20) && pos_q <= PosW'(23)) begin
      si_d = {si_q[23:0], b};
    end else if (pos_q >= PosW'(236) && pos_q <= PosW'(239)) begin
      if (b != cookie_byte(bi)) cm_d = 1'b0;
    end else if (pos_q >= PosW'(240)) begin
      for (int k = 0; k < 3; k++) begin
        if (ow_q[k] != 3'd0) begin
          ov_d[k] = {ov_q[k][23:0], b};
          ow_d[k] = ow_q[k] - 3'd1;
          if (ow_q[k] == 3'd1) of_d[k] = 1'b1;
        end
      end
      if (tp_q) begin
        tv_d = b; ts_d = 1'b1; tp_d = 1'b0;
      end
      unique case (ph_q)
        PhCode: begin
          if (b == OptEnd) ph_d = PhDone;
          else if (b != OptPad) begin
            skip_d = b; ph_d = PhLength;
          end
        end
        PhLength: begin
          if (skip_q == OptType && !ts_q && !tp_q) tp_d = 1'b1;
          for (int k = 0; k < 3; k++)
            if (skip_q == tcode[k] && !of_q[k] && ow_q[k] == 3'd0) ow_d[k] = 3'd4;
          skip_d = b;
          ph_d = (b == 8'd0) ? PhCode : PhSkip;
        end
        PhSkip: begin
          skip_d = skip_q - 8'd1;
          if (skip_q == 8'd1) ph_d = PhCode;
        end
        default: ;
      endcase
    end
    if (pos_q < MaxPos) pos_d = pos_q + PosW'(1);

    // the final byte itself may complete the type or an option value
    if (in_q.last_byte) begin
      if (in_q.udp_port != port_q) vd = VdPort;
      else if (pos_q < PosW'(240)) vd = VdShort;
      else if (pos_q >= MaxPos) vd = VdLong;
      else if (!xm_d) vd = VdXid;
      else if (!cm_d) vd = VdCookie;
      else if (!ts_d) vd = VdNoType;
      else if (tv_d == MsgOffer && !ot_q) begin
        vd = VdOffer; la_d = yi_d; ls_d = of_d[0] ? ov_d[0] : si_d; ot_d = 1'b1;
      end else if (tv_d == MsgAck && !at_q) begin
        vd = VdAck;
        if (of_d[1]) lm_d = ov_d[1];
        lg_d = of_d[2] ? ov_d[2] : ls_q;
        at_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q <= XidReset; port_q <= PortReset;
      in_vld_q <= 1'b0; out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgXid) xid_q <= cfg_data_i;
        else port_q <= cfg_data_i[15:0];
      end
      if (in_if.ready) in_vld_q <= in_if.valid;
      out_vld_q <= (fire && in_q.last_byte && !in_q.operation) ||
                   (out_vld_q && !out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready) in_q <= in_if.data;
    if (fire && in_q.last_byte && !in_q.operation) begin
      out_q.verdict <= vd;
      out_q.offered_address <= la_d;
      out_q.server_address <= ls_d;
      out_q.subnet_mask <= lm_d;
      out_q.gateway_address <= lg_d;
      out_q.lease_bound <= at_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ot_q <= 1'b0; at_q <= 1'b0; la_q <= '0; ls_q <= '0; lm_q <= MaskReset; lg_q <= '0;
    end else if (fire) begin
      if (in_q.operation) begin
        ot_q <= 1'b0; at_q <= 1'b0; la_q <= '0; ls_q <= '0; lm_q <= MaskReset; lg_q <= '0;
      end else begin
        ot_q <= ot_d; at_q <= at_d; la_q <= la_d; ls_q <= ls_d; lm_q <= lm_d; lg_q <= lg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; xm_q <= 1'b1; cm_q <= 1'b1; yi_q <= '0; si_q <= '0; ph_q <= PhCode;
      skip_q <= '0; ts_q <= 1'b0; tp_q <= 1'b0; tv_q <= '0; of_q <= '0;
      for (int k = 0; k < 3; k++) begin
        ov_q[k] <= '0; ow_q[k] <= '0;
      end
    end else if (fire) begin
      if (in_q.operation || in_q.last_byte) begin
        pos_q <= '0; xm_q <= 1'b1; cm_q <= 1'b1; yi_q <= '0; si_q <= '0; ph_q <= PhCode;
        skip_q <= '0; ts_q <= 1'b0; tp_q <= 1'b0; tv_q <= '0; of_q <= '0;
        for (int k = 0; k < 3; k++) begin
          ov_q[k] <= '0; ow_q[k] <= '0;
        end
      end else begin
        pos_q <= pos_d; xm_q <= xm_d; cm_q <= cm_d; yi_q <= yi_d; si_q <= si_d;
        ph_q <= ph_d; skip_q <= skip_d; ts_q <= ts_d; tp_q <= tp_d; tv_q <= tv_d;
        of_q <= of_d; ov_q <= ov_d; ow_q <= ow_d;
      end
    end
  end
endmodule

@@ hw/rtl/dhcp_checker.sv @@
// Port-level checks for the DHCP reply parser, bound to its top level.
// Depends on dhcp_pkg.
module dhcp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input dhcp_pkg::result_t out_data_i
);
  import dhcp_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.verdict <= 4'(VdAck))
    else $error("verdict code out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.verdict == 4'(VdAck) |-> out_data_i.lease_bound)
    else $error("ack without bound lease");
endmodule

bind dhcp_reply_parser dhcp_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
